FILE: src/chunked_transfer_tracker_macros.svh
// ----------------------------------------------------------------------------
// Chunked transfer tracker assertion macros
// Shared concurrent assertion shorthands for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_TRANSFER_TRACKER_MACROS_SVH
`define CHUNKED_TRANSFER_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ctt_pkg.sv
// ----------------------------------------------------------------------------
// Chunked transfer tracker package
// Constants, codes, the table row type and the FNV-1a-64 byte step.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;
    localparam logic [31:0] HEADER_BYTES   = 32'd4096;
    localparam logic [31:0] PART_SIZE_RST  = 32'd4194304;
    localparam int          MAX_ENTRIES_DEF = 32;

    typedef enum logic [2:0] {
        CMD_PREPARE = 3'd0,
        CMD_START   = 3'd1,
        CMD_DATA    = 3'd2,
        CMD_END     = 3'd3,
        CMD_FINISH  = 3'd4,
        CMD_COMMIT  = 3'd5,
        CMD_ABORT   = 3'd6
    } cmd_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_DUP_OK    = 4'd1;
    localparam logic [3:0] ST_NOT_READY = 4'd2;
    localparam logic [3:0] ST_BAD_INDEX = 4'd3;
    localparam logic [3:0] ST_DUP_BAD   = 4'd4;
    localparam logic [3:0] ST_BAD_START = 4'd5;
    localparam logic [3:0] ST_PATH_SEQ  = 4'd6;
    localparam logic [3:0] ST_INDEX_SEQ = 4'd7;
    localparam logic [3:0] ST_FULL      = 4'd8;
    localparam logic [3:0] ST_MISSING   = 4'd9;
    localparam logic [3:0] ST_CSUM_BAD  = 4'd10;
    localparam logic [3:0] ST_BAD_COMMIT = 4'd11;
    localparam logic [3:0] ST_TOO_LARGE = 4'd12;

    typedef struct packed {
        logic [63:0] path;
        logic [31:0] offset;
        logic [31:0] size;
        logic [63:0] hash;
    } row_t;

    // One FNV-1a-64 step; the prime 2^40 + 0x1b3 is applied as shifts and adds.
    function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

FILE: src/ctt_table.sv
// ----------------------------------------------------------------------------
// Chunked transfer tracker file table
// One-write, one-read synchronous memory holding the finished file entries.
// ----------------------------------------------------------------------------
module ctt_table #(
    parameter int Depth = ctt_pkg::MAX_ENTRIES_DEF,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AddrW-1:0]    wr_addr,
    input  ctt_pkg::row_t       wr_data,
    input  logic                rd_en,
    input  logic [AddrW-1:0]    rd_addr,
    output ctt_pkg::row_t       rd_data
);

    ctt_pkg::row_t mem [Depth];
    ctt_pkg::row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/chunked_transfer_tracker.sv
// ----------------------------------------------------------------------------
// Chunked transfer tracker
// Checks a chunked multi-file upload and builds its file table.
// ----------------------------------------------------------------------------
// Data bytes stream in at one per cycle while the request channel is ready,
// and update the chunk and file FNV-1a-64 hashes. Chunk end, finish, prepare
// and abort each answer with one result. That result is loaded into the
// output register at the edge that takes the request, and it shows on the
// next cycle. A commit reads the file table back one entry at a time:
// ST_CREAD starts the registered table read, and ST_CEMIT passes the entry
// on once the output register is free. The input side is held off until the
// last entry is handed to the output register. Results wait in a single
// output register, and a new request is taken whenever the tracker is idle
// and that register is empty or drained in the same cycle. The table needs
// no clearing pass after reset: only written entries are ever read.
module chunked_transfer_tracker #(
    parameter int MAX_ENTRIES = ctt_pkg::MAX_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] path_id, [95:64] chunk_number, [103:96] data_value,
    // [135:104] amount, [199:136] expected_hash, [200] hash_check_enable
    input  logic [207:0] s_tdata,
    // [2:0] command
    input  logic [2:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] status, [35:4] write_offset, [99:36] entry_path_id,
    // [131:100] entry_offset, [163:132] entry_size, [227:164] entry_hash,
    // [233:228] entry_total, [265:234] end_cursor
    output logic [271:0] m_tdata,
    output logic         m_tlast,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

`include "chunked_transfer_tracker_macros.svh"

    localparam int AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CntW  = $clog2(MAX_ENTRIES + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREAD,
        ST_CEMIT
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  part_size_reg;
    logic         prepared_reg, prepared_next;
    logic [31:0]  cursor_reg, cursor_next;
    logic [CntW-1:0] entries_reg, entries_next;
    logic         file_open_reg, file_open_next;
    logic [63:0]  open_path_reg, open_path_next;
    logic [31:0]  open_offset_reg, open_offset_next;
    logic [31:0]  open_size_reg, open_size_next;
    logic [63:0]  open_hash_reg, open_hash_next;
    logic [31:0]  next_num_reg, next_num_next;
    logic         prior_valid_reg, prior_valid_next;
    logic [31:0]  prior_num_reg, prior_num_next;
    logic [31:0]  prior_len_reg, prior_len_next;
    logic [63:0]  prior_hash_reg, prior_hash_next;
    logic [63:0]  pend_path_reg, pend_path_next;
    logic [31:0]  pend_num_reg, pend_num_next;
    logic [31:0]  pend_len_reg, pend_len_next;
    logic [63:0]  pend_hash_reg, pend_hash_next;
    logic [63:0]  tent_hash_reg, tent_hash_next;
    logic [CntW-1:0] ctot_reg, ctot_next;
    logic [31:0]  cend_reg, cend_next;
    logic [AddrW-1:0] cidx_reg, cidx_next;
    logic         out_valid_reg, out_valid_next;
    logic [271:0] out_data_reg, out_data_next;
    logic         out_last_reg, out_last_next;

    // Request fields.
    logic [2:0]   in_cmd;
    logic [63:0]  in_path;
    logic [31:0]  in_num;
    logic [7:0]   in_byte;
    logic [31:0]  in_amount;
    logic [63:0]  in_expect;
    logic         in_check;

    assign in_cmd    = s_tuser;
    assign in_path   = s_tdata[63:0];
    assign in_num    = s_tdata[95:64];
    assign in_byte   = s_tdata[103:96];
    assign in_amount = s_tdata[135:104];
    assign in_expect = s_tdata[199:136];
    assign in_check  = s_tdata[200];

    logic out_free;
    logic s_fire;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Table memory.
    logic            tbl_wr_en;
    logic            tbl_rd_en;
    ctt_pkg::row_t   tbl_wr_data;
    ctt_pkg::row_t   tbl_rd_data;

    ctt_table #(
        .Depth (MAX_ENTRIES),
        .AddrW (AddrW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (entries_reg[AddrW-1:0]),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (cidx_reg),
        .rd_data (tbl_rd_data)
    );

    assign tbl_wr_data = '{path: in_path, offset: open_offset_reg,
                           size: open_size_reg, hash: open_hash_reg};

    // APB: one register at byte addresses 0 to 3 (paddr[2] low).
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? part_size_reg : 32'd0;

    // Chunk end arithmetic. The aligned file start is the cursor rounded up
    // to a multiple of four, with a carry that flags a 32-bit overflow.
    logic [32:0] aligned33;
    logic        is_first;
    logic        dup_hit;
    logic [31:0] base;
    logic [32:0] end33;
    logic        over_cap;
    logic [31:0] len_inc;
    logic [32:0] prep_req;

    assign aligned33 = ({1'b0, cursor_reg} + 33'd3) & ~33'd3;
    assign is_first  = (pend_num_reg == 32'd0);
    assign dup_hit   = file_open_reg && (open_path_reg == pend_path_reg) &&
                       prior_valid_reg && (pend_num_reg == prior_num_reg);
    assign base      = is_first ? aligned33[31:0] : cursor_reg;
    assign end33     = {1'b0, base} + {1'b0, pend_len_reg};
    assign over_cap  = end33 > {1'b0, part_size_reg};
    assign len_inc   = (pend_len_reg == 32'hFFFFFFFF) ? pend_len_reg : pend_len_reg + 32'd1;
    assign prep_req  = (in_amount != 32'd0) ? ({1'b0, in_amount} + {1'b0, ctt_pkg::HEADER_BYTES})
                                            : {1'b0, part_size_reg};

    // Result word: status and write offset only; the commit fields are zero.
    function automatic logic [271:0] simple_result(input logic [3:0] st, input logic [31:0] wo);
        logic [271:0] r;
        r = '0;
        r[3:0]  = st;
        r[35:4] = wo;
        return r;
    endfunction

    logic [3:0]  end_status;
    logic [31:0] end_woff;

    always_comb begin
        state_next       = state_reg;
        prepared_next    = prepared_reg;
        cursor_next      = cursor_reg;
        entries_next     = entries_reg;
        file_open_next   = file_open_reg;
        open_path_next   = open_path_reg;
        open_offset_next = open_offset_reg;
        open_size_next   = open_size_reg;
        open_hash_next   = open_hash_reg;
        next_num_next    = next_num_reg;
        prior_valid_next = prior_valid_reg;
        prior_num_next   = prior_num_reg;
        prior_len_next   = prior_len_reg;
        prior_hash_next  = prior_hash_reg;
        pend_path_next   = pend_path_reg;
        pend_num_next    = pend_num_reg;
        pend_len_next    = pend_len_reg;
        pend_hash_next   = pend_hash_reg;
        tent_hash_next   = tent_hash_reg;
        ctot_next        = ctot_reg;
        cend_next        = cend_reg;
        cidx_next        = cidx_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        tbl_wr_en        = 1'b0;
        tbl_rd_en        = 1'b0;
        end_status       = ctt_pkg::ST_OK;
        end_woff         = 32'd0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_cmd) inside
                        ctt_pkg::CMD_PREPARE: begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (prep_req > {1'b0, part_size_reg}) begin
                                out_data_next = simple_result(ctt_pkg::ST_TOO_LARGE, 32'd0);
                            end else begin
                                out_data_next    = simple_result(ctt_pkg::ST_OK, 32'd0);
                                prepared_next    = 1'b1;
                                cursor_next      = ctt_pkg::HEADER_BYTES;
                                entries_next     = '0;
                                file_open_next   = 1'b0;
                                open_path_next   = 64'd0;
                                open_offset_next = 32'd0;
                                open_size_next   = 32'd0;
                                open_hash_next   = ctt_pkg::FNV_BASIS;
                                next_num_next    = 32'd0;
                                prior_valid_next = 1'b0;
                                prior_num_next   = 32'd0;
                                prior_len_next   = 32'd0;
                                prior_hash_next  = 64'd0;
                                pend_path_next   = 64'd0;
                                pend_num_next    = 32'd0;
                                pend_len_next    = 32'd0;
                                pend_hash_next   = ctt_pkg::FNV_BASIS;
                                tent_hash_next   = ctt_pkg::FNV_BASIS;
                            end
                        end
                        ctt_pkg::CMD_START: begin
                            pend_path_next = in_path;
                            pend_num_next  = in_num;
                            pend_len_next  = 32'd0;
                            pend_hash_next = ctt_pkg::FNV_BASIS;
                            tent_hash_next = (in_num == 32'd0) ? ctt_pkg::FNV_BASIS
                                                               : open_hash_reg;
                        end
                        ctt_pkg::CMD_DATA: begin
                            pend_hash_next = ctt_pkg::fnv_byte(pend_hash_reg, in_byte);
                            tent_hash_next = ctt_pkg::fnv_byte(tent_hash_reg, in_byte);
                            pend_len_next  = len_inc;
                        end
                        ctt_pkg::CMD_END: begin
                            if (!prepared_reg || pend_len_reg == 32'd0) begin
                                end_status = ctt_pkg::ST_NOT_READY;
                            end else if (pend_num_reg == 32'hFFFFFFFF) begin
                                end_status = ctt_pkg::ST_BAD_INDEX;
                            end else if (dup_hit) begin
                                end_status = (pend_len_reg == prior_len_reg &&
                                              pend_hash_reg == prior_hash_reg)
                                             ? ctt_pkg::ST_DUP_OK : ctt_pkg::ST_DUP_BAD;
                            end else if (is_first &&
                                         (file_open_reg || entries_reg >= MaxCnt)) begin
                                end_status = ctt_pkg::ST_BAD_START;
                            end else if (is_first && aligned33[32]) begin
                                end_status = ctt_pkg::ST_FULL;
                            end else if (!is_first &&
                                         (!file_open_reg || open_path_reg != pend_path_reg)) begin
                                end_status = ctt_pkg::ST_PATH_SEQ;
                            end else if (!is_first && pend_num_reg != next_num_reg) begin
                                end_status = ctt_pkg::ST_INDEX_SEQ;
                            end else begin
                                // A first chunk opens the file even when it
                                // then fails the capacity check.
                                if (is_first) begin
                                    cursor_next      = base;
                                    file_open_next   = 1'b1;
                                    open_path_next   = pend_path_reg;
                                    open_offset_next = base;
                                    open_size_next   = 32'd0;
                                    open_hash_next   = ctt_pkg::FNV_BASIS;
                                    next_num_next    = 32'd0;
                                    prior_valid_next = 1'b0;
                                end
                                if (over_cap) begin
                                    end_status = ctt_pkg::ST_FULL;
                                end else begin
                                    end_woff         = base;
                                    open_hash_next   = tent_hash_reg;
                                    open_size_next   = (is_first ? 32'd0 : open_size_reg)
                                                       + pend_len_reg;
                                    cursor_next      = end33[31:0];
                                    prior_valid_next = 1'b1;
                                    prior_num_next   = pend_num_reg;
                                    prior_len_next   = pend_len_reg;
                                    prior_hash_next  = pend_hash_reg;
                                    next_num_next    = pend_num_reg + 32'd1;
                                end
                            end
                            pend_len_next  = 32'd0;
                            pend_hash_next = ctt_pkg::FNV_BASIS;
                            tent_hash_next = is_first ? ctt_pkg::FNV_BASIS : open_hash_next;
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            out_data_next  = simple_result(end_status, end_woff);
                        end
                        ctt_pkg::CMD_FINISH: begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (!prepared_reg || !file_open_reg || open_path_reg != in_path) begin
                                out_data_next = simple_result(ctt_pkg::ST_MISSING, 32'd0);
                            end else if (in_amount != open_size_reg ||
                                         (in_check && in_expect != open_hash_reg)) begin
                                out_data_next = simple_result(ctt_pkg::ST_CSUM_BAD, 32'd0);
                            end else if (entries_reg >= MaxCnt) begin
                                out_data_next = simple_result(ctt_pkg::ST_MISSING, 32'd0);
                            end else begin
                                out_data_next    = simple_result(ctt_pkg::ST_OK, 32'd0);
                                tbl_wr_en        = 1'b1;
                                entries_next     = entries_reg + 1'b1;
                                file_open_next   = 1'b0;
                                open_path_next   = 64'd0;
                                open_offset_next = 32'd0;
                                open_size_next   = 32'd0;
                                open_hash_next   = ctt_pkg::FNV_BASIS;
                                next_num_next    = 32'd0;
                                prior_valid_next = 1'b0;
                                prior_num_next   = 32'd0;
                                prior_len_next   = 32'd0;
                                prior_hash_next  = 64'd0;
                            end
                        end
                        ctt_pkg::CMD_COMMIT, ctt_pkg::CMD_ABORT: begin
                            if (in_cmd == ctt_pkg::CMD_COMMIT &&
                                (!prepared_reg || file_open_reg || entries_reg == '0)) begin
                                out_valid_next = 1'b1;
                                out_last_next  = 1'b1;
                                out_data_next  = simple_result(ctt_pkg::ST_BAD_COMMIT, 32'd0);
                            end else begin
                                if (in_cmd == ctt_pkg::CMD_COMMIT) begin
                                    // Latch the run size and end cursor, then
                                    // clear the transfer while the table drains.
                                    ctot_next  = entries_reg;
                                    cend_next  = cursor_reg;
                                    cidx_next  = '0;
                                    state_next = ST_CREAD;
                                end else begin
                                    out_valid_next = 1'b1;
                                    out_last_next  = 1'b1;
                                    out_data_next  = simple_result(ctt_pkg::ST_OK, 32'd0);
                                end
                                prepared_next    = 1'b0;
                                cursor_next      = 32'd0;
                                entries_next     = '0;
                                file_open_next   = 1'b0;
                                open_path_next   = 64'd0;
                                open_offset_next = 32'd0;
                                open_size_next   = 32'd0;
                                open_hash_next   = ctt_pkg::FNV_BASIS;
                                next_num_next    = 32'd0;
                                prior_valid_next = 1'b0;
                                prior_num_next   = 32'd0;
                                prior_len_next   = 32'd0;
                                prior_hash_next  = 64'd0;
                                pend_path_next   = 64'd0;
                                pend_num_next    = 32'd0;
                                pend_len_next    = 32'd0;
                                pend_hash_next   = ctt_pkg::FNV_BASIS;
                                tent_hash_next   = ctt_pkg::FNV_BASIS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CREAD: begin
                tbl_rd_en  = 1'b1;
                state_next = ST_CEMIT;
            end
            ST_CEMIT: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_data_next           = '0;
                    out_data_next[99:36]    = tbl_rd_data.path;
                    out_data_next[131:100]  = tbl_rd_data.offset;
                    out_data_next[163:132]  = tbl_rd_data.size;
                    out_data_next[227:164]  = tbl_rd_data.hash;
                    out_data_next[233:228]  = 6'(ctot_reg);
                    out_data_next[265:234]  = cend_reg;
                    out_last_next           = ({1'b0, cidx_reg} + 1'b1) == (AddrW+1)'(ctot_reg);
                    if (out_last_next) begin
                        state_next = ST_IDLE;
                    end else begin
                        cidx_next  = cidx_reg + 1'b1;
                        state_next = ST_CREAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            part_size_reg   <= ctt_pkg::PART_SIZE_RST;
            prepared_reg    <= 1'b0;
            cursor_reg      <= 32'd0;
            entries_reg     <= '0;
            file_open_reg   <= 1'b0;
            open_path_reg   <= 64'd0;
            open_offset_reg <= 32'd0;
            open_size_reg   <= 32'd0;
            open_hash_reg   <= ctt_pkg::FNV_BASIS;
            next_num_reg    <= 32'd0;
            prior_valid_reg <= 1'b0;
            prior_num_reg   <= 32'd0;
            prior_len_reg   <= 32'd0;
            prior_hash_reg  <= 64'd0;
            pend_path_reg   <= 64'd0;
            pend_num_reg    <= 32'd0;
            pend_len_reg    <= 32'd0;
            pend_hash_reg   <= ctt_pkg::FNV_BASIS;
            tent_hash_reg   <= ctt_pkg::FNV_BASIS;
            ctot_reg        <= '0;
            cidx_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_wr) begin
                part_size_reg <= pwdata;
            end
            prepared_reg    <= prepared_next;
            cursor_reg      <= cursor_next;
            entries_reg     <= entries_next;
            file_open_reg   <= file_open_next;
            open_path_reg   <= open_path_next;
            open_offset_reg <= open_offset_next;
            open_size_reg   <= open_size_next;
            open_hash_reg   <= open_hash_next;
            next_num_reg    <= next_num_next;
            prior_valid_reg <= prior_valid_next;
            prior_num_reg   <= prior_num_next;
            prior_len_reg   <= prior_len_next;
            prior_hash_reg  <= prior_hash_next;
            pend_path_reg   <= pend_path_next;
            pend_num_reg    <= pend_num_next;
            pend_len_reg    <= pend_len_next;
            pend_hash_reg   <= pend_hash_next;
            tent_hash_reg   <= tent_hash_next;
            ctot_reg        <= ctot_next;
            cidx_reg        <= cidx_next;
            out_valid_reg   <= out_valid_next;
        end
        cend_reg     <= cend_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // The table count never passes its depth.
    `CTT_ASSERT_IMPL(a_entries_bound, aclk, aresetn, 1'b1, entries_reg <= MaxCnt, "table count overflow")
    // An open file only exists inside a prepared transfer.
    `CTT_ASSERT_IMPL(a_open_prepared, aclk, aresetn, file_open_reg, prepared_reg, "file open while unprepared")
    // No request is taken while a commit run drains.
    `CTT_ASSERT_IMPL(a_commit_block, aclk, aresetn, state_reg != ST_IDLE, !s_tready, "request taken during commit")
    // The last entry of a run returns the sequencer to idle.
    `CTT_ASSERT_NEXT(a_run_end, aclk, aresetn, state_reg == ST_CEMIT && out_free && out_last_next, state_reg == ST_IDLE, "commit run did not end")

endmodule
